FILE: rtl/core/dh_pkg.sv
// ----------------------------------------------------------------------------
// dh_pkg
// Shared constants for the joint transform: default formats, CORDIC gain
// and the arctangent table.
// ----------------------------------------------------------------------------
package dh_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int CORDIC_STAGES_DEF  = 16;

  // internal CORDIC format is Q2.30
  localparam int INT_FRAC = 30;
  // datapath width of the CORDIC x, y and z registers
  localparam int CW       = 34;

  localparam logic [31:0] GAIN_Q30 = 32'd652032874;

  // atan(2^-i) as a fraction of a full turn, 32-bit phase units
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/dh_cordic.sv
// ----------------------------------------------------------------------------
// dh_cordic
// Pipelined rotation-mode CORDIC: cosine and sine of a 16-bit binary angle,
// one stage per iteration, between an input register and an output register.
// ----------------------------------------------------------------------------
module dh_cordic
  import dh_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF,
  localparam int TW            = TRIG_FRAC_BITS + 2
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [15:0]          angle,
  output logic signed [TW-1:0] cos_o,
  output logic signed [TW-1:0] sin_o
);

  localparam logic [32:0] LOW_MASK = (33'd1 << (32 - ANGLE_BITS)) - 33'd1;
  localparam logic [31:0] KEEP     = ~LOW_MASK[31:0];
  localparam int          SH       = INT_FRAC - TRIG_FRAC_BITS;

  logic signed [CW-1:0] x_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_r [CORDIC_STAGES+1];
  logic signed [CW-1:0] z_r [CORDIC_STAGES+1];
  logic                 flip_r [CORDIC_STAGES+1];

  logic [31:0] phase;
  logic [31:0] phase_q;
  logic        flip_nxt;

  // fold the left half plane onto the right one, negate at the end
  always_comb begin
    phase    = {angle, 16'h0000} & KEEP;
    phase_q  = phase + 32'h40000000;
    flip_nxt = phase_q[31];
    if (flip_nxt) begin
      phase = phase ^ 32'h80000000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CW'(GAIN_Q30);
      y_r[0]    <= '0;
      z_r[0]    <= {{(CW-32){phase[31]}}, phase};
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [31:0] ATAN = atan_val(5'(i));
    logic signed [CW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - $signed({2'b00, ATAN});
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + $signed({2'b00, ATAN});
        end
      end
    end
  end

  logic signed [CW-1:0] xf, yf, xr, yr;
  logic signed [TW-1:0] cos_r, sin_r;

  assign xf = flip_r[CORDIC_STAGES] ? -x_r[CORDIC_STAGES] : x_r[CORDIC_STAGES];
  assign yf = flip_r[CORDIC_STAGES] ? -y_r[CORDIC_STAGES] : y_r[CORDIC_STAGES];

  if (SH == 0) begin : g_noround
    assign xr = xf;
    assign yr = yf;
  end else begin : g_round
    localparam logic signed [CW-1:0] HALF = CW'(1) <<< (SH - 1);
    assign xr = (xf + HALF) >>> SH;
    assign yr = (yf + HALF) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xr[TW-1:0];
      sin_r <= yr[TW-1:0];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

FILE: rtl/core/dh_joint_transform.sv
// ----------------------------------------------------------------------------
// dh_joint_transform
// One Denavit-Hartenberg joint transform per word: rotation and translation
// of the upper 3x4 part of the standard DH matrix.
// ----------------------------------------------------------------------------
// A word is accepted every cycle in which out_ready is high or the output
// register is empty. Its stages are one phase fold stage, one stage per
// CORDIC iteration, one rounding stage, one multiply stage and one
// round/saturate stage. The whole pipe stalls as one when the output word
// is held, so nothing is lost or repeated.
// Trig terms are Q1.TRIG_FRAC_BITS, translation is Q8.8 saturated to 16 bits.
module dh_joint_transform
  import dh_pkg::*;
#(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES  = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_joint_angle,
  input  logic signed [15:0] in_link_offset,
  input  logic signed [15:0] in_link_length,
  input  logic signed [15:0] in_twist_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_r00,
  output logic signed [15:0] out_r01,
  output logic signed [15:0] out_r02,
  output logic signed [15:0] out_px,
  output logic signed [15:0] out_r10,
  output logic signed [15:0] out_r11,
  output logic signed [15:0] out_r12,
  output logic signed [15:0] out_py,
  output logic signed [15:0] out_r21,
  output logic signed [15:0] out_r22,
  output logic signed [15:0] out_pz
);

  localparam int TW   = TRIG_FRAC_BITS + 2;
  localparam int PW   = TW + 16;              // a times trig product width
  localparam int WW   = (2 * TW > PW) ? 2 * TW + 2 : PW + 2;  // with headroom
  localparam int CLAT = CORDIC_STAGES + 2;    // CORDIC latency
  localparam int LAT  = CLAT + 2;             // total latency

  localparam logic signed [WW-1:0] SMAX = WW'(32767);
  localparam logic signed [WW-1:0] SMIN = -SMAX - WW'(1);
  localparam logic signed [WW-1:0] HALF = WW'(1) <<< (TRIG_FRAC_BITS - 1);

  // global stall: advance unless a finished word is waiting
  logic en;
  assign en       = out_ready | ~out_valid;
  assign in_ready = en;

  // valid bits ride along with the data
  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // sin/cos of theta and alpha
  logic signed [TW-1:0] ct, st, ca, sa;

  dh_cordic #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_theta (
    .clk  (clk),
    .en   (en),
    .angle(in_joint_angle),
    .cos_o(ct),
    .sin_o(st)
  );

  dh_cordic #(
    .ANGLE_BITS    (ANGLE_BITS),
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_alpha (
    .clk  (clk),
    .en   (en),
    .angle(in_twist_angle),
    .cos_o(ca),
    .sin_o(sa)
  );

  // d and a delay line matching the CORDIC
  logic signed [15:0] d_r [CLAT];
  logic signed [15:0] a_r [CLAT];

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= in_link_offset;
      a_r[0] <= in_link_length;
      for (int i = 1; i < CLAT; i++) begin
        d_r[i] <= d_r[i-1];
        a_r[i] <= a_r[i-1];
      end
    end
  end

  // multiply stage
  logic signed [2*TW-1:0] p_stca_r, p_stsa_r, p_ctca_r, p_ctsa_r;
  logic signed [PW-1:0]   p_act_r, p_ast_r;
  logic signed [TW-1:0]   ct_r, st_r, ca_r, sa_r;
  logic signed [15:0]     dm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_stca_r <= st * ca;
      p_stsa_r <= st * sa;
      p_ctca_r <= ct * ca;
      p_ctsa_r <= ct * sa;
      p_act_r  <= PW'(a_r[CLAT-1]) * PW'(ct);
      p_ast_r  <= PW'(a_r[CLAT-1]) * PW'(st);
      ct_r     <= ct;
      st_r     <= st;
      ca_r     <= ca;
      sa_r     <= sa;
      dm_r     <= d_r[CLAT-1];
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [WW-1:0] v);
    logic signed [15:0] r;
    if (v > SMAX) begin
      r = 16'sh7FFF;
    end else if (v < SMIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [WW-1:0] rnd(input logic signed [WW-1:0] v);
    return (v + HALF) >>> TRIG_FRAC_BITS;
  endfunction

  // round and saturate stage
  logic signed [15:0] r00_r, r01_r, r02_r, px_r, r10_r, r11_r, r12_r;
  logic signed [15:0] py_r, r21_r, r22_r, pz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r00_r <= sat16(WW'(ct_r));
      r01_r <= sat16(rnd(-WW'(p_stca_r)));
      r02_r <= sat16(rnd(WW'(p_stsa_r)));
      px_r  <= sat16(rnd(WW'(p_act_r)));
      r10_r <= sat16(WW'(st_r));
      r11_r <= sat16(rnd(WW'(p_ctca_r)));
      r12_r <= sat16(rnd(-WW'(p_ctsa_r)));
      py_r  <= sat16(rnd(WW'(p_ast_r)));
      r21_r <= sat16(WW'(sa_r));
      r22_r <= sat16(WW'(ca_r));
      pz_r  <= dm_r;
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_r00   = r00_r;
  assign out_r01   = r01_r;
  assign out_r02   = r02_r;
  assign out_px    = px_r;
  assign out_r10   = r10_r;
  assign out_r11   = r11_r;
  assign out_r12   = r12_r;
  assign out_py    = py_r;
  assign out_r21   = r21_r;
  assign out_r22   = r22_r;
  assign out_pz    = pz_r;

endmodule

FILE: rtl/core/dh_checker.sv
// ----------------------------------------------------------------------------
// dh_checker
// Port-level checks on the joint transform, bound to the top level.
// ----------------------------------------------------------------------------
module dh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_r00,
  input logic [15:0] out_px,
  input logic [15:0] out_pz
);

  // held word stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // held payload stable
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_r00) && $stable(out_px) && $stable(out_pz))
    else $error("output payload changed while stalled");

  // empty output never blocks input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind dh_joint_transform dh_checker u_dh_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_r00  (out_r00),
  .out_px   (out_px),
  .out_pz   (out_pz)
);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the joint transform block: a short table of directed words, then
// random words under random idling and back pressure, each result compared
// field by field against a bit-accurate CORDIC model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import dh_pkg::*;

  localparam int N_RANDOM   = 1830;
  localparam int LATENCY    = CORDIC_STAGES_DEF + 4;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_ROWS     = 20;

  typedef struct packed {
    logic signed [15:0] theta;
    logic signed [15:0] d;
    logic signed [15:0] a;
    logic signed [15:0] alpha;
  } joint_t;

  typedef struct packed {
    logic signed [15:0] r00, r01, r02, px;
    logic signed [15:0] r10, r11, r12, py;
    logic signed [15:0] r21, r22, pz;
  } frame_t;

  // directed row: joint word, whether a typed-in frame applies, that frame
  typedef struct {
    joint_t jw;
    bit     typed;
    frame_t fr;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_joint_angle = '0, in_link_offset = '0;
  logic signed [15:0] in_link_length = '0, in_twist_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  frame_t got;

  always #6 clk = ~clk;

  dh_joint_transform u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_joint_angle(in_joint_angle), .in_link_offset(in_link_offset),
    .in_link_length(in_link_length), .in_twist_angle(in_twist_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_r00(got.r00), .out_r01(got.r01), .out_r02(got.r02), .out_px(got.px),
    .out_r10(got.r10), .out_r11(got.r11), .out_r12(got.r12), .out_py(got.py),
    .out_r21(got.r21), .out_r22(got.r22), .out_pz(got.pz)
  );

  frame_t frames_due[$];
  int     n_err = 0;
  int     n_words_in = 0;
  int     n_words_out = 0;
  int     idle_pct = 29;     // set to 0 for the no-idle stretch
  bit     rx_hold = 1'b0;    // long receiver hold-off request
  bit     stim_done = 1'b0;

  // ---------------------------------------------------------------- predictor
  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // rotation-mode CORDIC on a binary angle; cos/sin in Q1.14
  function automatic void trig_of(input logic [15:0] ang,
                                  output longint c, output longint s);
    logic [31:0] ph;
    logic [31:0] sum;
    bit flip;
    longint x, y, z, xs, ys;
    ph = {ang, 16'h0000};
    ph &= ~((32'd1 << (32 - ANGLE_BITS_DEF)) - 32'd1);
    sum = ph + 32'h4000_0000;
    flip = sum[31];
    if (flip) ph ^= 32'h8000_0000;
    z = longint'($signed(ph));
    x = longint'(GAIN_Q30);
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      xs = asr64(x, i);
      ys = asr64(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_tab_of(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_tab_of(i));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = rnd_shift(x, INT_FRAC - TRIG_FRAC_BITS_DEF);
    s = rnd_shift(y, INT_FRAC - TRIG_FRAC_BITS_DEF);
  endfunction

  // own arctangent table, 32-bit phase units
  function automatic logic [31:0] atan_tab_of(int i);
    logic [31:0] t [0:15] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    return t[i];
  endfunction

  function automatic frame_t dh_frame(joint_t j);
    longint ct, st, ca, sa, a;
    frame_t f;
    trig_of(j.theta, ct, st);
    trig_of(j.alpha, ca, sa);
    a = longint'(j.a);
    f.r00 = clamp16(ct);
    f.r01 = clamp16(rnd_shift(-(st * ca), TRIG_FRAC_BITS_DEF));
    f.r02 = clamp16(rnd_shift(st * sa, TRIG_FRAC_BITS_DEF));
    f.px  = clamp16(rnd_shift(a * ct, TRIG_FRAC_BITS_DEF));
    f.r10 = clamp16(st);
    f.r11 = clamp16(rnd_shift(ct * ca, TRIG_FRAC_BITS_DEF));
    f.r12 = clamp16(rnd_shift(-(ct * sa), TRIG_FRAC_BITS_DEF));
    f.py  = clamp16(rnd_shift(a * st, TRIG_FRAC_BITS_DEF));
    f.r21 = clamp16(sa);
    f.r22 = clamp16(ca);
    f.pz  = j.d;
    return f;
  endfunction

  // ------------------------------------------------------------- directed table
  // Typed frames only for the zero-angle identity cases; CORDIC residue makes
  // other angles a model job.
  function automatic row_t mk(logic [15:0] th, logic [15:0] d, logic [15:0] a,
                              logic [15:0] al);
    row_t r;
    r.jw = '{th, d, a, al};
    r.typed = 1'b0;
    r.fr = '0;
    return r;
  endfunction

  row_t rows [N_ROWS];

  initial begin
    rows[0]  = mk(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    rows[1]  = mk(16'h4000, 16'h0100, 16'h0100, 16'h0000);   // theta = +90
    rows[2]  = mk(16'hC000, 16'h0100, 16'h0100, 16'h4000);   // theta = -90
    rows[3]  = mk(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);   // both at -180
    rows[4]  = mk(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);   // just under +180
    rows[5]  = mk(16'h3FFF, 16'h0000, 16'h7FFF, 16'h3FFF);   // fold boundary below
    rows[6]  = mk(16'hBFFF, 16'h0000, 16'h8000, 16'hBFFF);   // fold boundary above
    rows[7]  = mk(16'h2000, 16'h7FFF, 16'h7FFF, 16'hE000);   // theta = +45, alpha = -45
    rows[8]  = mk(16'hA000, 16'h8000, 16'h7FFF, 16'h6000);
    rows[9]  = mk(16'h6000, 16'hFFFF, 16'h8000, 16'hA000);
    rows[10] = mk(16'h0001, 16'h0001, 16'h0001, 16'hFFFF);   // smallest angles
    rows[11] = mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001);
    rows[12] = mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);   // alternating bits
    rows[13] = mk(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    rows[14] = mk(16'h1234, 16'h0080, 16'hFF80, 16'h4321);   // rounding halves
    rows[15] = mk(16'hC001, 16'h7FFF, 16'h7FFF, 16'h3FFF);
    rows[16] = mk(16'h4001, 16'h8000, 16'h8000, 16'hC001);
    rows[17] = mk(16'h8001, 16'h0000, 16'h4000, 16'h7FFE);
    rows[18] = mk(16'h0000, 16'h1234, 16'h7FFF, 16'h0000);
    rows[19] = mk(16'h0000, 16'h8000, 16'h8000, 16'h0000);
    // zero angles: identity rotation, px = a, pz = d
    rows[0].typed = 1'b1;
    rows[0].fr = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                   16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                   16'sd0, 16'sd16384, 16'sd0};
    rows[18].typed = 1'b1;
    rows[18].fr = '{16'sd16384, 16'sd0, 16'sd0, 16'sh7FFF,
                    16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                    16'sd0, 16'sd16384, 16'sh1234};
    rows[19].typed = 1'b1;
    rows[19].fr = '{16'sd16384, 16'sd0, 16'sd0, -16'sd32768,
                    16'sd0, 16'sd16384, 16'sd0, 16'sd0,
                    16'sd0, 16'sd16384, -16'sd32768};
  end

  // ------------------------------------------------------------------ sender
  // valid drops only when an idle cycle is taken, so back-to-back words keep
  // valid high across the boundary
  task automatic send_word(joint_t j);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_joint_angle <= j.theta;
    in_link_offset <= j.d;
    in_link_length <= j.a;
    in_twist_angle <= j.alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic joint_t rand_joint();
    joint_t j;
    j = {$urandom, $urandom};
    // mostly modest offsets/lengths so the translation is not always clamped
    if ($urandom_range(3, 0) != 0) begin
      j.a = $signed(16'($urandom_range(8191, 0))) - 16'sd4096;
      j.d = $signed(16'($urandom_range(8191, 0))) - 16'sd4096;
    end
    return j;
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].typed && rows[k].fr !== dh_frame(rows[k].jw)) begin
        n_err++;
        $display("ERROR: row %0d typed frame disagrees with predictor", k);
      end
      send_word(rows[k].jw);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) idle_pct = 0;             // no-idle stretch
      if (n == 600) idle_pct = 29;
      if (n == 900) rx_hold = 1'b1;           // receiver stalls, pipe fills
      if (n == 1300) begin                    // sender pauses until drained
        in_valid <= 1'b0;
        wait (frames_due.size() == 0);
        @(negedge clk);
      end
      send_word(rand_joint());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------- receiver
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        rx_hold = 1'b0;
      end
      out_ready <= ($urandom_range(99, 0) >= idle_pct);
    end
  end

  // ------------------------------------------------- scoreboard and watchdog
  int quiet = 0;

  always @(posedge clk) begin
    frame_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (in_valid && in_ready) begin
        frames_due.push_back(dh_frame('{in_joint_angle, in_link_offset,
                                        in_link_length, in_twist_angle}));
        n_words_in++;
      end
      if (out_valid && out_ready) begin
        n_words_out++;
        if (frames_due.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("ERROR: result word with nothing pending");
        end else begin
          want = frames_due.pop_front();
          if (got !== want) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: word %0d\n  exp %p\n  got %p", n_words_out, want, got);
          end
        end
      end
    end
  end

  initial begin
    fork
      begin
        wait (stim_done && frames_due.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      wait (quiet >= WDOG_LIMIT);
    join_any
    disable fork;
    if (quiet >= WDOG_LIMIT || frames_due.size() != 0) begin
      n_err++;
      $display("ERROR: stalled or %0d frames never arrived", frames_due.size());
    end
    $display("Ran %0d joint words (directed extremes, random, stalls); %0d frames back",
             n_words_in, n_words_out);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
